/* hdl/srf_pkg.sv */
package srf_pkg;

    localparam int DEF_WINDOW_BITS = 2048;
    localparam logic [39:0] REJECT_AFTER_RESET = 40'd180000000;
    localparam logic [7:0]  TRANSPORT_TYPE = 8'd4;
    localparam logic [16:0] OVERHEAD_LEN = 17'd32;   // header 16 + tag 16

    typedef enum logic [1:0] {
        REQ_INSTALL = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_SEND    = 2'd2,
        REQ_RECEIVE = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SESSION = 3'd1,
        ST_BAD_PACKET = 3'd2,
        ST_BUF_SMALL  = 3'd3,
        ST_CTR_EXHAUST = 3'd4,
        ST_CRYPTO_FAIL = 3'd5,
        ST_REPLAY     = 3'd6
    } status_code_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_SHIFT,
        FSM_RESP
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [62:0] now_us;
        logic [31:0] key_local_index;
        logic [31:0] key_remote_index;
        logic        key_initiator;
        logic [7:0]  msg_type;
        logic [15:0] data_len;
        logic [15:0] buf_cap;
        logic [31:0] rx_receiver_index;
        logic [63:0] rx_counter;
        logic        crypto_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        accepted;
        logic        session_used;
        logic [15:0] out_len;
        logic [31:0] tx_remote_index;
        logic [63:0] tx_counter;
        logic        prev_expired;
        logic [31:0] replay_drop_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic shift_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic shift_start;
        logic shift_last;
    } sts_t;

endpackage

/* hdl/srf_ctrl.sv */
module srf_ctrl
    import srf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != FSM_IDLE);
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_EVAL;
                end
            end
            FSM_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.shift_start ? FSM_SHIFT : FSM_RESP;
            end
            FSM_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_last)
                    state_next = FSM_RESP;
            end
            FSM_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/srf_dpath.sv */
module srf_dpath
    import srf_pkg::*;
#(
    parameter int WINDOW_BITS = DEF_WINDOW_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [39:0] cfg_data,
    input  req_t        in_data,
    output rsp_t        out_data,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int SHW  = $clog2(WINDOW_BITS);
    localparam int STGW = $clog2(SHW);

    logic [39:0] reject_reg;

    logic                   valid_reg [2], valid_next [2];
    logic                   conf_reg  [2], conf_next  [2];
    logic [62:0]            born_reg  [2], born_next  [2];
    logic [31:0]            loc_reg   [2], loc_next   [2];
    logic [31:0]            rem_reg   [2], rem_next   [2];
    logic [63:0]            sc_reg    [2], sc_next    [2];
    logic [63:0]            rmax_reg  [2], rmax_next  [2];
    logic [WINDOW_BITS-1:0] bm_reg    [2], bm_next    [2];
    logic [31:0]            drop_reg, drop_next;

    logic [SHW-1:0]  shamt_reg, shamt_next;
    logic            sgen_reg, sgen_next;
    logic [STGW-1:0] stg_reg, stg_next;

    req_t req_reg;
    rsp_t res_reg, res_next;
    rsp_t out_reg;

    logic                   g;
    logic [16:0]            need;
    logic [15:0]            plen;
    logic [63:0]            top, fwd, back, age;
    logic [SHW-1:0]         bidx;
    logic                   m0, m1;
    logic [WINDOW_BITS-1:0] sh_bm;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            valid_next[i] = valid_reg[i];
            conf_next[i]  = conf_reg[i];
            born_next[i]  = born_reg[i];
            loc_next[i]   = loc_reg[i];
            rem_next[i]   = rem_reg[i];
            sc_next[i]    = sc_reg[i];
            rmax_next[i]  = rmax_reg[i];
            bm_next[i]    = bm_reg[i];
        end
        drop_next       = drop_reg;
        shamt_next      = shamt_reg;
        sgen_next       = sgen_reg;
        stg_next        = stg_reg;
        res_next        = res_reg;
        sts.shift_start = 1'b0;
        sts.shift_last  = (stg_reg == STGW'(SHW - 1));
        g     = 1'b0;
        need  = 17'(req_reg.data_len) + OVERHEAD_LEN;
        plen  = req_reg.data_len - 16'(OVERHEAD_LEN);
        m0    = valid_reg[0] && (req_reg.rx_receiver_index == loc_reg[0]);
        m1    = valid_reg[1] && (req_reg.rx_receiver_index == loc_reg[1]);
        top   = 64'd0;
        fwd   = 64'd0;
        back  = 64'd0;
        bidx  = '0;
        age   = {1'b0, req_reg.now_us} - {1'b0, born_reg[1]};
        sh_bm = bm_reg[sgen_reg];

        if (cmd.eval)
        begin
            res_next = '0;
            stg_next = '0;
            unique case (req_reg.req_type)
                REQ_INSTALL:
                begin
                    if (valid_reg[0] && (conf_reg[0] || !valid_reg[1]))
                    begin
                        valid_next[1] = valid_reg[0];
                        conf_next[1]  = conf_reg[0];
                        born_next[1]  = born_reg[0];
                        loc_next[1]   = loc_reg[0];
                        rem_next[1]   = rem_reg[0];
                        sc_next[1]    = sc_reg[0];
                        rmax_next[1]  = rmax_reg[0];
                        bm_next[1]    = bm_reg[0];
                    end
                    valid_next[0] = 1'b1;
                    conf_next[0]  = req_reg.key_initiator;
                    born_next[0]  = req_reg.now_us;
                    loc_next[0]   = req_reg.key_local_index;
                    rem_next[0]   = req_reg.key_remote_index;
                    sc_next[0]    = 64'd0;
                    rmax_next[0]  = 64'd0;
                    bm_next[0]    = '0;
                end
                REQ_TICK:
                begin
                    if (valid_reg[1] && (req_reg.now_us >= born_reg[1])
                        && (age >= {24'd0, reject_reg}))
                    begin
                        valid_next[1] = 1'b0;
                        conf_next[1]  = 1'b0;
                        born_next[1]  = '0;
                        loc_next[1]   = '0;
                        rem_next[1]   = '0;
                        sc_next[1]    = '0;
                        rmax_next[1]  = '0;
                        bm_next[1]    = '0;
                        res_next.prev_expired = 1'b1;
                    end
                end
                REQ_SEND:
                begin
                    if (!valid_reg[0] && !valid_reg[1])
                        res_next.status = ST_NO_SESSION;
                    else
                    begin
                        g = !(valid_reg[0] && conf_reg[0]) && valid_reg[1];
                        res_next.session_used = g;
                        if ({1'b0, req_reg.buf_cap} < need)
                            res_next.status = ST_BUF_SMALL;
                        else if (&sc_reg[g])
                            res_next.status = ST_CTR_EXHAUST;
                        else if (!req_reg.crypto_ok)
                            res_next.status = ST_CRYPTO_FAIL;
                        else
                        begin
                            res_next.accepted        = 1'b1;
                            res_next.out_len         = need[15:0];
                            res_next.tx_remote_index = rem_reg[g];
                            res_next.tx_counter      = sc_reg[g];
                            sc_next[g]               = sc_reg[g] + 64'd1;
                        end
                    end
                end
                REQ_RECEIVE:
                begin
                    if ((req_reg.data_len < 16'(OVERHEAD_LEN))
                        || (req_reg.msg_type != TRANSPORT_TYPE))
                        res_next.status = ST_BAD_PACKET;
                    else if (!m0 && !m1)
                        res_next.status = ST_NO_SESSION;
                    else
                    begin
                        g = !m0;
                        res_next.session_used = g;
                        top  = rmax_reg[g];
                        fwd  = req_reg.rx_counter - top;
                        back = top - req_reg.rx_counter;
                        bidx = back[SHW-1:0];
                        if (req_reg.buf_cap < plen)
                            res_next.status = ST_BUF_SMALL;
                        else if (!req_reg.crypto_ok)
                            res_next.status = ST_CRYPTO_FAIL;
                        else if (req_reg.rx_counter > top)
                        begin
                            rmax_next[g] = req_reg.rx_counter;
                            if (fwd >= 64'(WINDOW_BITS))
                                bm_next[g] = WINDOW_BITS'(1);
                            else
                            begin
                                sts.shift_start = 1'b1;
                                shamt_next      = fwd[SHW-1:0];
                                sgen_next       = g;
                            end
                            res_next.accepted = 1'b1;
                            res_next.out_len  = plen;
                            if (!g)
                                conf_next[0] = 1'b1;
                        end
                        else if ((back >= 64'(WINDOW_BITS)) || bm_reg[g][bidx])
                        begin
                            res_next.status = ST_REPLAY;
                            drop_next       = drop_reg + 32'd1;
                        end
                        else
                        begin
                            bm_next[g][bidx]  = 1'b1;
                            res_next.accepted = 1'b1;
                            res_next.out_len  = plen;
                            if (!g)
                                conf_next[0] = 1'b1;
                        end
                    end
                end
                default: res_next = '0;
            endcase
            res_next.replay_drop_count = drop_next;
        end

        // one barrel stage per cycle, stage k shifts by 2**k
        if (cmd.shift_step)
        begin
            for (int k = 0; k < SHW; k++)
            begin
                if ((stg_reg == STGW'(k)) && shamt_reg[k])
                    sh_bm = bm_reg[sgen_reg] << (1 << k);
            end
            if (sts.shift_last)
                sh_bm[0] = 1'b1;
            bm_next[sgen_reg] = sh_bm;
            stg_next          = stg_reg + STGW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_reg <= REJECT_AFTER_RESET;
            drop_reg   <= '0;
            for (int i = 0; i < 2; i++)
            begin
                valid_reg[i] <= 1'b0;
                conf_reg[i]  <= 1'b0;
                born_reg[i]  <= '0;
                loc_reg[i]   <= '0;
                rem_reg[i]   <= '0;
                sc_reg[i]    <= '0;
                rmax_reg[i]  <= '0;
                bm_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                reject_reg <= cfg_data;
            drop_reg <= drop_next;
            for (int i = 0; i < 2; i++)
            begin
                valid_reg[i] <= valid_next[i];
                conf_reg[i]  <= conf_next[i];
                born_reg[i]  <= born_next[i];
                loc_reg[i]   <= loc_next[i];
                rem_reg[i]   <= rem_next[i];
                sc_reg[i]    <= sc_next[i];
                rmax_reg[i]  <= rmax_next[i];
                bm_reg[i]    <= bm_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_data;
        if (cmd.out_load)
            out_reg <= res_reg;
        res_reg   <= res_next;
        shamt_reg <= shamt_next;
        sgen_reg  <= sgen_next;
        stg_reg   <= stg_next;
    end

    assign out_data = out_reg;

endmodule

/* hdl/session_replay_filter.sv */
// Session replay filter: two key generations (current, previous) with a
// per-generation anti-replay window.
// Input channel in_valid/in_stall/in_data carries one request: install,
// expiry tick, send or receive. Output channel out_valid/out_stall/out_data
// returns exactly one response per request, in order.
// Config: cfg_we/cfg_data writes reject_after_us; write only while idle.
// From acceptance a request passes the evaluate state, then the response
// state, which loads the output register and raises out_valid. A receive
// that moves the window forward by less than WINDOW_BITS first passes the
// shift state (one barrel-shifter stage per cycle on the stored bitmap).
// in_stall is high while a request is in flight, so no new one is taken.
// A finished response sits in the output register; the next request is
// taken while it waits, and is held before its own response is loaded
// until out_stall drops.
// Reset: both generations invalid, windows and drop count cleared,
// reject_after_us back to 180 s, no response pending.
module session_replay_filter
    import srf_pkg::*;
#(
    parameter int WINDOW_BITS = DEF_WINDOW_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [39:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: accept, evaluate, optional window slide, respond
    srf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // generation state, windows and response registers
    srf_dpath #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
